@@ rtl/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranging block.
// No dependencies; every other file in rtl/ but uer_if.sv imports this package.
package uer_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [1:0] CFG_WAIT_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_ECHO_LIMIT    = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd1;
  localparam logic [15:0] WAIT_LIMIT_RST    = 16'd6250;
  localparam logic [11:0] ECHO_LIMIT_RST    = 12'd1500;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // ticks * 343 / 125 as one multiply: 343 * ceil(2^28 / 125), then drop 28 bits.
  // Exact for every 12-bit tick count.
  localparam int unsigned  MM_SHIFT = 28;
  localparam logic [29:0]  MM_MUL   = 30'd736587012;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_ECHO = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] wait_limit;
    logic [11:0] echo_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_word_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        no_echo;
    logic [13:0] distance_mm;
  } out_word_t;

endpackage

@@ rtl/uer_if.sv @@
// Valid/ready channel interfaces for the tick input and the result output.
// Standalone; no package needed.
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic        busy_res;
  logic        done_res;
  logic        no_echo;
  logic [13:0] distance_mm;

  modport source (output valid, output trigger_level, output busy_res, output done_res,
                  output no_echo, output distance_mm, input ready);
  modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                  input no_echo, input distance_mm, output ready);
endinterface

@@ rtl/uer_cfg_regs.sv @@
// Configuration register file: trigger length, wait limit and echo limit.
// Depends on uer_pkg.
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t             cfg
);

  cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TRIGGER_TICKS: cfg_nxt.trigger_ticks = cfg_wdata[7:0];
        CFG_WAIT_LIMIT:    cfg_nxt.wait_limit    = cfg_wdata;
        CFG_ECHO_LIMIT:    cfg_nxt.echo_limit    = cfg_wdata[11:0];
        default:           cfg_nxt = cfg_r;   // unknown index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks <= TRIGGER_TICKS_RST;
      cfg_r.wait_limit    <= WAIT_LIMIT_RST;
      cfg_r.echo_limit    <= ECHO_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/uer_ctrl.sv @@
// Measurement sequencer: phase and tick counter, result word per tick,
// tick-to-millimetre conversion. Depends on uer_pkg.
module uer_ctrl
  import uer_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  in_word,
  input  cfg_regs_t cfg,
  output out_word_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic [7:0]  tlen;
  logic [15:0] tlen_ext;
  logic [15:0] el_ext;
  logic [15:0] cnt_inc;
  logic [15:0] cnt_sat;
  logic [15:0] conv_raw;
  logic [11:0] conv_cnt;
  logic [41:0] mm_prod;
  logic        conv_en;
  logic        res_trig;
  logic        res_busy;
  logic        res_done;
  logic        res_noecho;
  logic [13:0] res_dist;

  assign tlen     = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
  assign tlen_ext = {8'd0, tlen};
  assign el_ext   = {4'd0, cfg.echo_limit};
  assign cnt_inc  = cnt_r + 16'd1;
  assign cnt_sat  = (cnt_r < CNT_MAX) ? cnt_inc : cnt_r;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    res_trig   = 1'b0;
    res_busy   = 1'b0;
    res_done   = 1'b0;
    res_noecho = 1'b0;
    conv_en    = 1'b0;
    conv_raw   = 16'd0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_word.start_req) begin
          res_trig = 1'b1;
          res_busy = 1'b1;
          if (tlen == 8'd1) begin
            phase_nxt = PH_WAIT;
            cnt_nxt   = 16'd0;
          end else begin
            phase_nxt = PH_TRIG;
            cnt_nxt   = 16'd1;
          end
        end
      end
      PH_TRIG: begin
        res_trig = 1'b1;
        res_busy = 1'b1;
        if (cnt_inc >= tlen_ext) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = 16'd0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_WAIT: begin
        if (in_word.echo_level) begin
          // rise tick is the first echo tick
          if (el_ext <= 16'd1) begin
            res_done  = 1'b1;
            conv_en   = 1'b1;
            conv_raw  = 16'd1;
            phase_nxt = PH_IDLE;
            cnt_nxt   = 16'd0;
          end else begin
            res_busy  = 1'b1;
            phase_nxt = PH_ECHO;
            cnt_nxt   = 16'd1;
          end
        end else if (cnt_sat >= cfg.wait_limit) begin
          res_done   = 1'b1;
          res_noecho = 1'b1;
          phase_nxt  = PH_IDLE;
          cnt_nxt    = 16'd0;
        end else begin
          res_busy = 1'b1;
          cnt_nxt  = cnt_sat;
        end
      end
      PH_ECHO: begin
        if (!in_word.echo_level) begin
          res_done  = 1'b1;
          conv_en   = 1'b1;
          conv_raw  = cnt_r;
          phase_nxt = PH_IDLE;
          cnt_nxt   = 16'd0;
        end else if (cnt_sat >= el_ext) begin
          res_done  = 1'b1;
          conv_en   = 1'b1;
          conv_raw  = cnt_sat;
          phase_nxt = PH_IDLE;
          cnt_nxt   = 16'd0;
        end else begin
          res_busy = 1'b1;
          cnt_nxt  = cnt_sat;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = 16'd0;
      end
    endcase
  end

  // clamp to the echo limit, which fits 12 bits
  assign conv_cnt = (conv_raw > el_ext) ? cfg.echo_limit : conv_raw[11:0];
  assign mm_prod  = 42'(conv_cnt) * 42'(MM_MUL);
  assign res_dist = conv_en ? mm_prod[MM_SHIFT+13:MM_SHIFT] : 14'd0;

  assign res = {res_trig, res_busy, res_done, res_noecho, res_dist};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/ultrasonic_echo_ranging.sv @@
// Top level of the ultrasonic echo ranging block: input register, sequencer,
// result register. Depends on uer_pkg, uer_if, uer_cfg_regs and uer_ctrl.
//
// Usage:
//   in_ch  - one word per timer tick: start_req and the sampled echo_level.
//   out_ch - exactly one word per input word: trigger_level, busy_res,
//            done_res, no_echo and distance_mm (ticks * 343 / 125).
//   cfg_*  - plain write port; index 0 trigger_ticks, 1 wait_limit,
//            2 echo_limit, other indexes are dropped. Write only while idle.
// Timing:
//   An accepted word passes the input register, then the result register,
//   before it is offered on out_ch. One word is taken every cycle while
//   out_ch is not stalled; the sequencer step is a single pass of compare and
//   multiply logic between the input register and the result register.
// Reset:
//   Synchronous, active low. Sequencer returns to idle, both stages empty,
//   registers take 1 / 6250 / 1500.
// Stalls:
//   While out_ch is held, the result register holds its word, the input
//   register takes one more word if empty, then in_ch.ready drops; nothing is lost.
module ultrasonic_echo_ranging
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  uer_in_if.sink                in_ch,
  uer_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t cfg;
  in_word_t  in_word_r;
  logic      in_vld_r;
  out_word_t out_word_r;
  logic      out_vld_r;
  out_word_t res;
  logic      adv;
  logic      step;
  logic      in_rdy;

  assign adv    = !out_vld_r || out_ch.ready;
  assign step   = in_vld_r && adv;
  assign in_rdy = !in_vld_r || adv;

  assign in_ch.ready = in_rdy;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word_r),
    .cfg     (cfg),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      in_word_r.start_req  <= in_ch.start_req;
      in_word_r.echo_level <= in_ch.echo_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.trigger_level = out_word_r.trigger_level;
  assign out_ch.busy_res      = out_word_r.busy_res;
  assign out_ch.done_res      = out_word_r.done_res;
  assign out_ch.no_echo       = out_word_r.no_echo;
  assign out_ch.distance_mm   = out_word_r.distance_mm;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for ultrasonic_echo_ranging: drives timer-tick words, predicts each result
// word with a small scoreboard class and checks the words in order of arrival.
// Depends on uer_pkg, the uer_in_if / uer_out_if interfaces and the RTL top level.
module testbench
  import uer_pkg::*;
();

  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  class ranging_board;
    phase_t      phase;
    int unsigned count;
    logic [7:0]  trig_len;
    logic [15:0] wait_lim;
    logic [11:0] echo_lim;
    out_word_t   due_words[$];
    int          errors;
    int          ticks;
    int          finished;
    int          no_echoes;
    int          saturated;
    int unsigned max_mm;

    function new();
      phase     = PH_IDLE;
      count     = 0;
      trig_len  = TRIGGER_TICKS_RST;
      wait_lim  = WAIT_LIMIT_RST;
      echo_lim  = ECHO_LIMIT_RST;
      errors    = 0;
      ticks     = 0;
      finished  = 0;
      no_echoes = 0;
      saturated = 0;
      max_mm    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_TRIGGER_TICKS: trig_len = data[7:0];
        CFG_WAIT_LIMIT:    wait_lim = data;
        CFG_ECHO_LIMIT:    echo_lim = data[11:0];
        default: ;
      endcase
    endfunction

    function logic [13:0] ticks_to_mm(int unsigned t);
      if (t > echo_lim) t = echo_lim;
      return 14'((t * 343) / 125);
    endfunction

    // Closing word of a measurement; return to idle
    function out_word_t close_word(bit lost);
      out_word_t w;
      w = '0;
      w.done_res    = 1'b1;
      w.no_echo     = lost;
      w.distance_mm = lost ? 14'd0 : ticks_to_mm(count);
      finished++;
      if (lost) no_echoes++;
      else if (count >= echo_lim) saturated++;
      if (w.distance_mm > max_mm) max_mm = w.distance_mm;
      phase = PH_IDLE;
      count = 0;
      return w;
    endfunction

    function void note_tick(logic start, logic echo);
      out_word_t   w;
      int unsigned tlen;
      w    = '0;
      tlen = (trig_len == 0) ? 1 : trig_len;
      ticks++;
      case (phase)
        PH_IDLE: if (start) begin
          w.trigger_level = 1'b1;
          w.busy_res      = 1'b1;
          count           = 1;
          phase           = PH_TRIG;
          if (count >= tlen) begin
            phase = PH_WAIT;
            count = 0;
          end
        end
        PH_TRIG: begin
          w.trigger_level = 1'b1;
          w.busy_res      = 1'b1;
          count           = (count + 1) & 16'hFFFF;
          if (count >= tlen) begin
            phase = PH_WAIT;
            count = 0;
          end
        end
        PH_WAIT: if (echo) begin
          // rise tick is the first echo tick
          count = 1;
          if (count >= echo_lim) w = close_word(1'b0);
          else begin
            w.busy_res = 1'b1;
            phase      = PH_ECHO;
          end
        end else begin
          if (count < CNT_MAX) count++;
          if (count >= wait_lim) w = close_word(1'b1);
          else w.busy_res = 1'b1;
        end
        default: if (echo) begin
          if (count < CNT_MAX) count++;
          if (count >= echo_lim) w = close_word(1'b0);
          else w.busy_res = 1'b1;
        end else begin
          w = close_word(1'b0);
        end
      endcase
      due_words.push_back(w);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        report("word with nothing outstanding", got, 0);
        return;
      end
      want = due_words.pop_front();
      if (got.trigger_level !== want.trigger_level)
        report("trigger_level", got.trigger_level, want.trigger_level);
      if (got.busy_res !== want.busy_res) report("busy_res", got.busy_res, want.busy_res);
      if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
      if (got.no_echo !== want.no_echo) report("no_echo", got.no_echo, want.no_echo);
      if (got.distance_mm !== want.distance_mm)
        report("distance_mm", got.distance_mm, want.distance_mm);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  uer_in_if  in_ch();
  uer_out_if out_ch();

  ranging_board board;
  out_word_t    seen_word;
  int           send_idle_pct;
  int           sink_stall_pct;
  int           hold_seq;
  int           ticks_sent;
  int           quiet_cycles = 0;
  int           cfg_trig;
  int           cfg_wait;
  int           cfg_echo;

  ultrasonic_echo_ranging DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  assign seen_word = {out_ch.trigger_level, out_ch.busy_res, out_ch.done_res,
                      out_ch.no_echo, out_ch.distance_mm};

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) board.note_tick(in_ch.start_req, in_ch.echo_level);
    if (rst_n && out_ch.valid && out_ch.ready) board.check_word(seen_word);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus a long hold whenever hold_seq moves
  initial begin : sink_side
    int hold_left;
    int seen_seq;
    hold_left    = 0;
    seen_seq     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Leaves valid high on return; callers drop it when the stream pauses
  task automatic send_tick(logic start, logic echo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.start_req  <= start;
    in_ch.echo_level <= echo;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  task automatic drain();
    do @(posedge clk); while (board.due_words.size() != 0);
  endtask

  // Bring the sequencer back to idle with every word delivered
  task automatic settle();
    in_ch.valid <= 1'b0;
    drain();
    while (board.phase != PH_IDLE) begin
      send_tick(1'b0, board.phase == PH_WAIT);
      in_ch.valid <= 1'b0;
      drain();
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Upper bits beyond the trigger and echo register widths carry junk and must be dropped
  task automatic apply_cfg(int trig, int wait_ticks, int echo);
    settle();
    write_reg(CFG_UNUSED_IDX, 16'($urandom));
    write_reg(CFG_TRIGGER_TICKS, {8'($urandom), 8'(trig)});
    write_reg(CFG_WAIT_LIMIT, 16'(wait_ticks));
    write_reg(CFG_ECHO_LIMIT, {4'($urandom), 12'(echo)});
    cfg_we   <= 1'b0;
    cfg_trig = trig;
    cfg_wait = wait_ticks;
    cfg_echo = echo;
  endtask

  function automatic logic stray_start();
    return $urandom_range(9) == 0;
  endfunction

  // One well-formed shot: trigger, quiet gap, echo pulse, falling tick
  task automatic measure(int delay, int len);
    int tl;
    tl = (cfg_trig == 0) ? 1 : cfg_trig;
    send_tick(1'b1, 1'($urandom));
    repeat (tl - 1) send_tick(stray_start(), 1'($urandom));
    repeat (delay) send_tick(stray_start(), 1'b0);
    repeat (len) send_tick(stray_start(), 1'b1);
    send_tick(1'($urandom), 1'b0);
  endtask

  task automatic random_phase(int n_items);
    int stop_at;
    int pick;
    stop_at = ticks_sent + n_items;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 15) repeat ($urandom_range(1, 6)) send_tick(1'($urandom), 1'($urandom));
      else if (pick < 25) measure($urandom_range(cfg_wait, cfg_wait + 3), $urandom_range(1, 3));
      else if (pick < 35)
        measure($urandom_range(0, cfg_wait - 1), $urandom_range(cfg_echo, cfg_echo + 4));
      else measure($urandom_range(0, cfg_wait - 1), $urandom_range(1, cfg_echo));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.start_req  = 1'b0;
    in_ch.echo_level = 1'b0;
    send_idle_pct    = 0;
    sink_stall_pct   = 0;
    hold_seq         = 0;
    ticks_sent       = 0;
    cfg_trig         = TRIGGER_TICKS_RST;
    cfg_wait         = WAIT_LIMIT_RST;
    cfg_echo         = ECHO_LIMIT_RST;
    board            = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle ticks ignored, start on the completion tick ignored
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    // Zero in every register: one trigger tick, instant no-echo, instant zero distance
    apply_cfg(0, 0, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);

    apply_cfg(1, 1, 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    apply_cfg(3, 2, 4095);
    measure(1, 2);

    // Full scale registers: longest trigger, largest limits, one short echo
    apply_cfg(255, 65535, 4095);
    measure(5, 20);

    for (int p = 0; p < 4; p++) begin
      apply_cfg($urandom_range(1, 4), $urandom_range(1, 24), $urandom_range(1, 30));
      case (p)
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct <= 0;
          hold_seq       <= hold_seq + 1;
        end
        1: begin
          send_idle_pct  = 85;
          sink_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct <= 85;
        end
        default: begin
          send_idle_pct  = 36;
          sink_stall_pct <= 36;
        end
      endcase
      random_phase(160);
    end

    in_ch.valid <= 1'b0;
    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d ticks: %0d measurements finished, %0d without echo, %0d saturated",
             board.ticks, board.finished, board.no_echoes, board.saturated);
    $display("Largest distance %0d mm; registers from zero to full scale, gaps, stalls, hold",
             board.max_mm);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
